// ===== hdl/apfm_pkg.sv =====
`timescale 1ns / 1ps
package apfm_pkg;

    // Fixed field widths
    localparam int CAPTURE_W = 16;
    localparam int TICK_W    = 24;
    localparam int GAIN_W    = 16;
    localparam int PPR_W     = 8;
    localparam int FREQ_W    = 34;
    localparam int SPEED_W   = 34;
    localparam int RPM_W     = 40;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    // Default build parameters
    localparam int WINDOW_DEF       = 5;
    localparam int CAPTURE_BITS_DEF = 16;

    // Register reset values
    localparam logic [TICK_W-1:0] TICK_RATE_RST = 24'd250000;
    localparam logic [GAIN_W-1:0] SPEED_GAIN_RST = 16'd6423;
    localparam logic [PPR_W-1:0]  PPR_RST = 8'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICK_RATE      = 2'd0,
        CFG_SPEED_GAIN     = 2'd1,
        CFG_REV_PULSES     = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FREQ,
        ST_RPM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic start_freq;
        logic start_rpm;
        logic publish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic window_full;
        logic sum_zero;
        logic div_busy;
        logic mul_busy;
        logic out_free;
    } ctrl_status_t;

endpackage

// ===== hdl/averaged_pulse_frequency_meter_core.sv =====
`timescale 1ns / 1ps
// Averaged pulse frequency meter.
// Input channel (s_valid/s_ready, s_capture_time): one request per rising
// edge capture of the sensor timer. The last WINDOW captures are kept and
// the gaps between neighbors are summed as they arrive.
// Result channel (m_valid/m_ready): freq_q8, speed_q8 and rpm_q8 for each
// capture once the window has filled and the gap sum is non-zero; other
// captures are absorbed with no result.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always
// ready; index 0 tick rate, 1 speed gain, 2 pulses per revolution.
// A capture that gives no result goes back to idle after the window check.
// One that gives a result runs two divides through a single radix-2
// divider, frequency first and then rpm; no new capture is accepted until
// that result has been put into the output register.
// The speed product is formed bit-serially during the rpm divide.
// Results go to an output register; the next capture is accepted while a
// result waits there, and a new result waits until the receiver takes it.
// Reset (aresetn, synchronous, active low) clears the window, the fill
// state and the output valid, and restores the register defaults.
module averaged_pulse_frequency_meter_core #(
    parameter int WINDOW       = apfm_pkg::WINDOW_DEF,
    parameter int CAPTURE_BITS = apfm_pkg::CAPTURE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [apfm_pkg::CAPTURE_W-1:0]  s_capture_time,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [apfm_pkg::FREQ_W-1:0]     m_freq_q8,
    output logic [apfm_pkg::SPEED_W-1:0]    m_speed_q8,
    output logic [apfm_pkg::RPM_W-1:0]      m_rpm_q8,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [apfm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [apfm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import apfm_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    assign cfg_ready = 1'b1;

    apfm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    apfm_datapath #(
        .WINDOW       (WINDOW),
        .CAPTURE_BITS (CAPTURE_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .capture_time (s_capture_time),
        .cfg_we       (cfg_valid & cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_freq_q8    (m_freq_q8),
        .m_speed_q8   (m_speed_q8),
        .m_rpm_q8     (m_rpm_q8)
    );

endmodule

// ===== hdl/apfm_div.sv =====
`timescale 1ns / 1ps
module apfm_div #(
    parameter int DIVIDEND_W = 40,
    parameter int DIVISOR_W  = 19
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient
);
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;

    logic [DIVISOR_W:0] rem_shift;
    logic [DIVISOR_W:0] diff;
    logic               take;

    // One quotient bit per cycle, restoring
    always_comb begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff      = rem_shift - {1'b0, dvs_reg};
        take      = ~diff[DIVISOR_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIVIDEND_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= take ? diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], take};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/apfm_datapath.sv =====
`timescale 1ns / 1ps
module apfm_datapath #(
    parameter int WINDOW       = apfm_pkg::WINDOW_DEF,
    parameter int CAPTURE_BITS = apfm_pkg::CAPTURE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  apfm_pkg::ctrl_cmd_t             cmd,
    output apfm_pkg::ctrl_status_t          status,
    input  logic [apfm_pkg::CAPTURE_W-1:0]  capture_time,
    input  logic                            cfg_we,
    input  logic [apfm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [apfm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            m_ready,
    output logic                            m_valid,
    output logic [apfm_pkg::FREQ_W-1:0]     m_freq_q8,
    output logic [apfm_pkg::SPEED_W-1:0]    m_speed_q8,
    output logic [apfm_pkg::RPM_W-1:0]      m_rpm_q8
);
    import apfm_pkg::*;

    localparam int CAP_W  = (CAPTURE_BITS < CAPTURE_W) ? CAPTURE_BITS : CAPTURE_W;
    localparam int SUM_W  = CAP_W + $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW);
    localparam int NUM_W  = TICK_W + 8 + $clog2(WINDOW);
    localparam int DIV_W  = (NUM_W > RPM_W) ? NUM_W : RPM_W;
    localparam int DVS_W  = (SUM_W > PPR_W) ? SUM_W : PPR_W;
    localparam int PROD_W = FREQ_W + GAIN_W;
    localparam int MCNT_W = $clog2(GAIN_W + 1);

    // Configuration registers
    logic [TICK_W-1:0] tick_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [PPR_W-1:0]  ppr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= TICK_RATE_RST;
            gain_reg <= SPEED_GAIN_RST;
            ppr_reg  <= PPR_RST;
        end else if (cfg_we) begin
            if (cfg_index == CFG_TICK_RATE) begin
                tick_reg <= cfg_data[TICK_W-1:0];
            end
            if (cfg_index == CFG_SPEED_GAIN) begin
                gain_reg <= cfg_data[GAIN_W-1:0];
            end
            if (cfg_index == CFG_REV_PULSES) begin
                ppr_reg <= cfg_data[PPR_W-1:0];
            end
        end
    end

    // Capture window with a running sum of neighbor gaps
    logic [CAP_W-1:0]  window_reg [WINDOW];
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [FILL_W-1:0] fill_reg;
    logic              full_reg;
    logic [CAP_W-1:0]  cap_in;
    logic [CAP_W-1:0]  gap_new;
    logic [CAP_W-1:0]  gap_old;

    always_comb begin
        cap_in  = capture_time[CAP_W-1:0];
        gap_new = (cap_in >= window_reg[0]) ? (cap_in - window_reg[0])
                                            : (window_reg[0] - cap_in);
        gap_old = (window_reg[WINDOW-2] >= window_reg[WINDOW-1])
                ? (window_reg[WINDOW-2] - window_reg[WINDOW-1])
                : (window_reg[WINDOW-1] - window_reg[WINDOW-2]);
        // Add the gap entering the window, drop the one shifted out
        sum_next = sum_reg + SUM_W'(gap_new) - SUM_W'(gap_old);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW; i++) begin
                window_reg[i] <= '0;
            end
            sum_reg  <= '0;
            fill_reg <= '0;
            full_reg <= 1'b0;
        end else if (cmd.load) begin
            window_reg[0] <= cap_in;
            for (int i = 1; i < WINDOW; i++) begin
                window_reg[i] <= window_reg[i-1];
            end
            sum_reg <= sum_next;
            if (!full_reg) begin
                if (fill_reg == FILL_W'(WINDOW - 1)) begin
                    full_reg <= 1'b1;
                end else begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
        end
    end

    // Shared divider: frequency first, then rpm
    logic [NUM_W-1:0]  numerator;
    logic [DIV_W-1:0]  quotient;
    logic [DIV_W-1:0]  div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    logic [FREQ_W-1:0] freq_sat;
    logic [RPM_W-1:0]  freq_x60;
    logic [PPR_W-1:0]  ppr_eff;
    logic              div_busy;

    always_comb begin
        numerator = NUM_W'(WINDOW - 1) * NUM_W'({tick_reg, 8'd0});
        freq_sat  = (|quotient[DIV_W-1:FREQ_W]) ? {FREQ_W{1'b1}} : quotient[FREQ_W-1:0];
        freq_x60  = {freq_sat, 6'd0} - RPM_W'({freq_sat, 2'd0});
        ppr_eff   = (ppr_reg == '0) ? PPR_W'(1) : ppr_reg;
        if (cmd.start_freq) begin
            div_dividend = DIV_W'(numerator);
            div_divisor  = DVS_W'(sum_reg);
        end else begin
            div_dividend = DIV_W'(freq_x60);
            div_divisor  = DVS_W'(ppr_eff);
        end
    end

    apfm_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (DVS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.start_freq | cmd.start_rpm),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // Shift-add multiplier for speed, runs alongside the rpm divide
    logic [FREQ_W-1:0] freq_reg;
    logic [PROD_W-1:0] mcand_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [GAIN_W-1:0] mplier_reg;
    logic [MCNT_W-1:0] mcnt_reg;
    logic              mul_busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_busy_reg <= 1'b0;
            mcnt_reg     <= '0;
        end else if (cmd.start_rpm) begin
            mul_busy_reg <= 1'b1;
            mcnt_reg     <= MCNT_W'(GAIN_W);
        end else if (mul_busy_reg) begin
            mcnt_reg <= mcnt_reg - 1'b1;
            if (mcnt_reg == MCNT_W'(1)) begin
                mul_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_rpm) begin
            freq_reg   <= freq_sat;
            mcand_reg  <= PROD_W'(freq_sat);
            mplier_reg <= gain_reg;
            acc_reg    <= '0;
        end else if (mul_busy_reg) begin
            if (mplier_reg[0]) begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[PROD_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[GAIN_W-1:1]};
        end
    end

    // Output register
    logic                m_valid_reg;
    logic [FREQ_W-1:0]   freq_out_reg;
    logic [SPEED_W-1:0]  speed_out_reg;
    logic [RPM_W-1:0]    rpm_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.publish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            freq_out_reg  <= freq_reg;
            speed_out_reg <= acc_reg[PROD_W-1:GAIN_W];
            rpm_out_reg   <= quotient[RPM_W-1:0];
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_freq_q8  = freq_out_reg;
    assign m_speed_q8 = speed_out_reg;
    assign m_rpm_q8   = rpm_out_reg;

    always_comb begin
        status.window_full = full_reg;
        status.sum_zero    = (sum_reg == '0);
        status.div_busy    = div_busy;
        status.mul_busy    = mul_busy_reg;
        status.out_free    = ~m_valid_reg | m_ready;
    end

endmodule

// ===== hdl/apfm_ctrl.sv =====
`timescale 1ns / 1ps
module apfm_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  apfm_pkg::ctrl_status_t status,
    output apfm_pkg::ctrl_cmd_t    cmd
);
    import apfm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // drop the request when the window is short or the gaps sum to zero
                if (!status.window_full || status.sum_zero) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.start_freq = 1'b1;
                    state_next     = ST_FREQ;
                end
            end
            ST_FREQ: begin
                if (!status.div_busy) begin
                    cmd.start_rpm = 1'b1;
                    state_next    = ST_RPM;
                end
            end
            ST_RPM: begin
                if (!status.div_busy && !status.mul_busy) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold until the output register is free
                if (status.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/apfm_checker.sv =====
`timescale 1ns / 1ps
module apfm_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [apfm_pkg::FREQ_W-1:0]     m_freq_q8,
    input logic [apfm_pkg::SPEED_W-1:0]    m_speed_q8,
    input logic [apfm_pkg::RPM_W-1:0]      m_rpm_q8
);
    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_freq_q8)
            && $stable(m_speed_q8) && $stable(m_rpm_q8))
        else $error("result changed while stalled");

    // An accepted request leaves the block not ready in the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted on two consecutive cycles");

    // Speed gain is below one, so speed never exceeds frequency
    a_speed_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_speed_q8 <= m_freq_q8)
        else $error("speed exceeds frequency");

    // rpm is at most 60 times frequency; checked against the looser bound of 64 times
    a_rpm_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_rpm_q8 <= {m_freq_q8, 6'd0})
        else $error("rpm exceeds bound");

    // Reset leaves no result pending
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind averaged_pulse_frequency_meter_core apfm_checker u_apfm_checker (.*);

// ===== dv/tb_averaged_pulse_frequency_meter_core.sv =====
`timescale 1ns / 1ps
module tb_averaged_pulse_frequency_meter_core;
    import apfm_pkg::*;

    localparam int WINDOW        = WINDOW_DEF;
    localparam int IDLE_PCT      = 21;
    localparam int SETTLE_CYCLES = 120;
    localparam int STALL_LIMIT   = 4000;
    localparam int REPORT_LIMIT  = 10;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS   = 100;
    localparam int STEADY_PHASE  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam logic [63:0] FREQ_LIMIT = (64'd1 << FREQ_W) - 64'd1;

    typedef struct packed {
        logic [FREQ_W-1:0]  freq;
        logic [SPEED_W-1:0] speed;
        logic [RPM_W-1:0]   rpm;
    } reading_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [CAPTURE_W-1:0]  s_capture_time;
    logic                  m_valid;
    logic                  m_ready;
    logic [FREQ_W-1:0]     m_freq_q8;
    logic [SPEED_W-1:0]    m_speed_q8;
    logic [RPM_W-1:0]      m_rpm_q8;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predictor state: capture history, fill tracking and register copies
    logic [CAPTURE_W-1:0] cap_hist [WINDOW];
    int unsigned          held_count;
    bit                   hist_full;
    logic [TICK_W-1:0]    tick_rate;
    logic [GAIN_W-1:0]    speed_gain;
    logic [PPR_W-1:0]     rev_pulses;

    reading_t expected_readings [$];
    reading_t want;
    int       mismatches;
    int       quiet_cycles;
    bit       steady;

    averaged_pulse_frequency_meter_core #(
        .WINDOW       (WINDOW),
        .CAPTURE_BITS (CAPTURE_BITS_DEF)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_capture_time (s_capture_time),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_freq_q8      (m_freq_q8),
        .m_speed_q8     (m_speed_q8),
        .m_rpm_q8       (m_rpm_q8),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic predict_reading(input logic [CAPTURE_W-1:0] capture);
        logic [63:0] gap_sum;
        logic [63:0] freq;
        logic [63:0] ppr_eff;
        reading_t    r;
        for (int i = WINDOW - 1; i > 0; i--) cap_hist[i] = cap_hist[i-1];
        cap_hist[0] = capture;
        if (!hist_full) begin
            if (held_count >= WINDOW - 1) hist_full = 1'b1;
            else held_count++;
        end
        if (!hist_full) return;
        gap_sum = 64'd0;
        for (int i = 0; i < WINDOW - 1; i++) begin
            if (cap_hist[i] >= cap_hist[i+1]) gap_sum += 64'(cap_hist[i] - cap_hist[i+1]);
            else gap_sum += 64'(cap_hist[i+1] - cap_hist[i]);
        end
        if (gap_sum == 64'd0) return;
        freq = (64'(WINDOW - 1) * 64'(tick_rate) * 64'd256) / gap_sum;
        if (freq > FREQ_LIMIT) freq = FREQ_LIMIT;
        ppr_eff = (rev_pulses == '0) ? 64'd1 : 64'(rev_pulses);
        r.freq  = freq[FREQ_W-1:0];
        r.speed = SPEED_W'((freq * 64'(speed_gain)) >> 16);
        r.rpm   = RPM_W'((freq * 64'd60) / ppr_eff);
        expected_readings.push_back(r);
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] want_v, got_v);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want_v, got_v);
    endtask

    // Drop s_valid, drain every pending reading, then let the core settle
    task automatic wait_for_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Leave s_valid high on return; the next request or an idle cycle replaces it
    task automatic send_capture(input logic [CAPTURE_W-1:0] capture);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_capture_time <= capture;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_reading(capture);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        wait_for_idle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_TICK_RATE:  tick_rate  = data[TICK_W-1:0];
            CFG_SPEED_GAIN: speed_gain = data[GAIN_W-1:0];
            CFG_REV_PULSES: rev_pulses = data[PPR_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_window_fill();
        // Four requests fill the window silently; the fifth gives the first reading
        send_capture(16'h0000);
        send_capture(16'hFFFF);
        send_capture(16'h0000);
        send_capture(16'hFFFF);
        send_capture(16'h0000);
        // Five equal captures bring the gap sum to zero
        repeat (5) send_capture(16'd1000);
        // One count of spread gives the highest frequency
        send_capture(16'd1001);
        wait_for_idle();
    endtask

    task automatic test_register_extremes();
        write_register(CFG_TICK_RATE, 24'hFFFFFF);
        write_register(CFG_SPEED_GAIN, 24'hFFFFFF);
        write_register(CFG_REV_PULSES, 24'hFFFF01);
        send_capture(16'd1001);
        // Zero pulses per revolution divides by one
        write_register(CFG_REV_PULSES, 24'h000000);
        send_capture(16'd1002);
        // Zero tick rate still emits a reading, all zero
        write_register(CFG_TICK_RATE, 24'h000000);
        send_capture(16'd1003);
        write_register(CFG_TICK_RATE, 24'h000001);
        write_register(CFG_SPEED_GAIN, 24'h000000);
        write_register(CFG_REV_PULSES, 24'h0000FF);
        send_capture(16'hFFFF);
        send_capture(16'h0000);
        write_register(CFG_SPARE_INDEX, 24'hA5A5A5);
        send_capture(16'h8000);
        write_register(CFG_TICK_RATE, CFG_DATA_W'(TICK_RATE_RST));
        write_register(CFG_SPEED_GAIN, CFG_DATA_W'(SPEED_GAIN_RST));
        write_register(CFG_REV_PULSES, CFG_DATA_W'(PPR_RST));
        send_capture(16'h7FFF);
        wait_for_idle();
    endtask

    task automatic test_random_readings();
        logic [CAPTURE_W-1:0]  prev;
        logic [CFG_DATA_W-1:0] tick_word;
        int unsigned           period;
        int unsigned           pick;
        prev = s_capture_time;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            pick = $urandom_range(99);
            if (pick < 10) tick_word = '0;
            else if (pick < 20) tick_word = '1;
            else if (pick < 60) tick_word = CFG_DATA_W'($urandom_range(1000, 1000000));
            else tick_word = CFG_DATA_W'($urandom_range(1, 24'hFFFFFF));
            write_register(CFG_TICK_RATE, tick_word);
            write_register(CFG_SPEED_GAIN, CFG_DATA_W'($urandom()));
            write_register(CFG_REV_PULSES, CFG_DATA_W'($urandom()));
            if ($urandom_range(1) == 1) write_register(CFG_SPARE_INDEX, CFG_DATA_W'($urandom()));
            steady = (p == STEADY_PHASE);
            if ($urandom_range(2) == 0) period = $urandom_range(1, 50);
            else period = $urandom_range(50, 20000);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                // Mostly a pulse train with jitter; wrap of the timer is kept
                if (pick < 70)
                    prev = prev + CAPTURE_W'(period) + CAPTURE_W'($urandom_range(0, 8))
                           - CAPTURE_W'(4);
                else if (pick < 82) prev = CAPTURE_W'($urandom());
                else if (pick >= 90) prev = prev + CAPTURE_W'($urandom_range(0, 3));
                send_capture(prev);
            end
        end
        steady = 1'b0;
    endtask

    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_readings.size() == 0) begin
                note_mismatch("unexpected reading, freq", 64'd0, 64'(m_freq_q8));
            end else begin
                want = expected_readings.pop_front();
                if (m_freq_q8 !== want.freq)
                    note_mismatch("freq_q8", 64'(want.freq), 64'(m_freq_q8));
                if (m_speed_q8 !== want.speed)
                    note_mismatch("speed_q8", 64'(want.speed), 64'(m_speed_q8));
                if (m_rpm_q8 !== want.rpm)
                    note_mismatch("rpm_q8", 64'(want.rpm), 64'(m_rpm_q8));
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL averaged_pulse_frequency_meter_core");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_capture_time = '0;
        m_ready        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_TICK_RATE;
        cfg_data       = '0;
        steady         = 1'b0;
        mismatches     = 0;
        quiet_cycles   = 0;
        tick_rate      = TICK_RATE_RST;
        speed_gain     = SPEED_GAIN_RST;
        rev_pulses     = PPR_RST;
        held_count     = 0;
        hist_full      = 1'b0;
        for (int i = 0; i < WINDOW; i++) cap_hist[i] = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_window_fill();
        test_register_extremes();
        test_random_readings();
        wait_for_idle();

        if (mismatches == 0 && expected_readings.size() == 0) begin
            $display("PASS averaged_pulse_frequency_meter_core");
        end else begin
            $display("FAIL averaged_pulse_frequency_meter_core");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/apfm_pkg.sv
hdl/apfm_div.sv
hdl/apfm_datapath.sv
hdl/apfm_ctrl.sv
hdl/averaged_pulse_frequency_meter_core.sv
hdl/apfm_checker.sv
dv/tb_averaged_pulse_frequency_meter_core.sv
